// ===== hdl/sptfs_pkg.sv =====
package sptfs_pkg;

  localparam int CHANNELS   = 6;
  localparam int CNT_W      = 16;
  localparam int REG_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int FRAC_W     = 32;
  localparam int WHOLE_W    = 16;
  localparam int FD_W       = WHOLE_W + FRAC_W;
  localparam int ES_W       = 64;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // compare widths for counters against 16-bit limits and against the Q16.32 delay
  localparam int LIM_CMP_W  = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int FD_CMP_W   = (CNT_W + FRAC_W > FD_W) ? CNT_W + FRAC_W : FD_W;

  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAP    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = CFG_IDX_W'(5);

  localparam logic [REG_W-1:0]  START_DELAY_RST  = REG_W'(208);
  localparam logic [REG_W-1:0]  HIGH_TICKS_RST   = REG_W'(83);
  localparam logic [REG_W-1:0]  PERIOD_TICKS_RST = REG_W'(500);
  localparam logic [REG_W-1:0]  PHASE_GAP_RST    = REG_W'(83);
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = GAIN_W'(4294967);
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = GAIN_W'(4295);

  typedef enum logic [1:0] {
    PH_DELAY = 2'd0,
    PH_HIGH  = 2'd1,
    PH_WAIT  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    PI_ES,
    PI_M0,
    PI_M1,
    PI_M2,
    PI_M3,
    PI_M4,
    PI_I,
    PI_T,
    PI_READY
  } pi_state_t;

  typedef struct packed {
    logic [CHANNELS-1:0] gate_lines;
    logic                period_start;
    logic [WHOLE_W-1:0]  delay_whole;
  } res_t;

endpackage

// ===== hdl/six_pulse_thyristor_firing_sequencer.sv =====
// Six-pulse gate sequencer. Each request carries one timebase tick flag and returns exactly
// one result: the six gate levels, a period-start flag and the whole part of the firing
// delay. A request is taken every clock cycle unless in_stall is raised; results sit in an
// output register backed by a one-entry skid stage, so an output stall costs no throughput
// until both are full. The proportional-integral delay update is precomputed by a sequencer
// around one shared 32x32 multiplier that steps through states ES, M0 to M4, I and T; it
// restarts after reset, after every configuration write and after every tick that closes a
// period. While it runs, it raises in_stall only when the next tick closes a period, so
// with a period of at least 9 ticks and no output stall the block sustains one request per
// cycle; with shorter periods a period-closing tick waits until the PI update is ready.
module six_pulse_thyristor_firing_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_tick,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sptfs_pkg::CHANNELS-1:0]       out_gate_lines,
  output logic                                 out_period_start,
  output logic [sptfs_pkg::WHOLE_W-1:0]        out_delay_whole,
  input  logic                                 cfg_we,
  input  logic [sptfs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sptfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sptfs_pkg::*;

  localparam logic signed [ES_W-1:0] ES_MAX = {1'b0, {(ES_W-1){1'b1}}};
  localparam logic signed [ES_W-1:0] ES_MIN = {1'b1, {(ES_W-1){1'b0}}};

  function automatic logic signed [ES_W-1:0] sat_add(input logic signed [ES_W-1:0] a,
                                                     input logic signed [ES_W-1:0] b);
    logic signed [ES_W-1:0] s;
    s = a + b;
    if (a[ES_W-1] == b[ES_W-1] && s[ES_W-1] != a[ES_W-1]) begin
      s = a[ES_W-1] ? ES_MIN : ES_MAX;
    end
    return s;
  endfunction

  // configuration
  logic [REG_W-1:0]  high_ticks_r, period_ticks_r, phase_gap_r;
  logic [GAIN_W-1:0] kp_r, ki_r;

  // sequencer state
  phase_t                 phase_r [CHANNELS];
  logic [CNT_W-1:0]       cnt_r   [CHANNELS];
  logic [CNT_W-1:0]       pc_r;
  logic [FD_W-1:0]        fd_r;
  logic signed [ES_W-1:0] es_r;
  logic [CHANNELS-1:0]    gate_r;

  // per-tick next values
  phase_t                 phase_v [CHANNELS];
  logic [CNT_W-1:0]       cnt_v   [CHANNELS];
  logic [CNT_W-1:0]       pc_v;
  logic [CHANNELS-1:0]    gate_v;
  logic [FD_W-1:0]        fd_v;
  logic signed [ES_W-1:0] es_v;
  logic                   started;
  logic                   reached;
  logic                   kick;

  logic [CNT_W-1:0] pc_inc;
  logic             period_due;
  logic             acc;
  res_t             res;

  // PI sequencer
  pi_state_t              pi_state_r, pi_state_nxt;
  logic                   pi_restart;
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            prod_nxt;
  logic [63:0]            prod_r;
  logic signed [ES_W-1:0] neg_fd;
  logic signed [ES_W-1:0] es1_r;
  logic [ES_W-1:0]        mag_r;
  logic                   neg_r;
  logic [FD_W+GAIN_W-1:0] accp_r;
  logic [ES_W+GAIN_W-1:0] acci_r;
  logic signed [ES_W-1:0] p_r, t1_r, i_r, t_sum;
  logic [FD_W-1:0]        pi_fd_r;
  logic signed [ES_W-1:0] pi_es_r;

  // output register and skid stage
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;

  assign pc_inc     = pc_r + 1'b1;
  assign period_due = LIM_CMP_W'(pc_inc) >= LIM_CMP_W'(period_ticks_r);
  assign in_stall   = skid_valid_r || (pi_state_r != PI_READY && period_due);
  assign acc        = in_valid && !in_stall;
  assign pi_restart = cfg_we || (acc && in_tick && period_due);

  // tick update: period end first, then the channel chain in order
  always_comb begin
    phase_v = phase_r;
    cnt_v   = cnt_r;
    pc_v    = pc_r;
    gate_v  = gate_r;
    fd_v    = fd_r;
    es_v    = es_r;
    started = 1'b0;
    reached = 1'b0;
    kick    = 1'b0;
    if (in_tick) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_v[i] = cnt_r[i] + 1'b1;
      end
      pc_v = pc_inc;
      if (period_due) begin
        fd_v       = pi_fd_r;
        es_v       = pi_es_r;
        phase_v[0] = PH_DELAY;
        cnt_v[0]   = '0;
        pc_v       = '0;
        started    = 1'b1;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        // predecessor fired this tick: rearm this channel
        if (kick) begin
          phase_v[i] = PH_DELAY;
          cnt_v[i]   = '0;
        end
        kick = 1'b0;
        if (i == 0) begin
          reached = (FD_CMP_W'(cnt_v[i]) << FRAC_W) >= FD_CMP_W'(fd_v);
        end else begin
          reached = LIM_CMP_W'(cnt_v[i]) >= LIM_CMP_W'(phase_gap_r);
        end
        if (phase_v[i] == PH_DELAY && reached) begin
          gate_v[i]  = 1'b1;
          phase_v[i] = PH_HIGH;
          cnt_v[i]   = '0;
          kick       = 1'b1;
        end else if (phase_v[i] == PH_HIGH &&
                     LIM_CMP_W'(cnt_v[i]) >= LIM_CMP_W'(high_ticks_r)) begin
          gate_v[i]  = 1'b0;
          phase_v[i] = PH_WAIT;
          cnt_v[i]   = '0;
        end
      end
    end
  end

  always_comb begin
    res.gate_lines   = gate_v;
    res.period_start = started;
    res.delay_whole  = fd_v[FD_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_ticks_r   <= HIGH_TICKS_RST;
      period_ticks_r <= PERIOD_TICKS_RST;
      phase_gap_r    <= PHASE_GAP_RST;
      kp_r           <= PROP_GAIN_RST;
      ki_r           <= INTEG_GAIN_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i] <= PH_DELAY;
        cnt_r[i]   <= '0;
      end
      pc_r   <= '0;
      fd_r   <= {START_DELAY_RST, FRAC_W'(0)};
      es_r   <= '0;
      gate_r <= '0;
    end else begin
      if (acc) begin
        phase_r <= phase_v;
        cnt_r   <= cnt_v;
        pc_r    <= pc_v;
        fd_r    <= fd_v;
        es_r    <= es_v;
        gate_r  <= gate_v;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_START_DELAY:  fd_r           <= {cfg_wdata[REG_W-1:0], FRAC_W'(0)};
          REG_HIGH_TICKS:   high_ticks_r   <= cfg_wdata[REG_W-1:0];
          REG_PERIOD_TICKS: period_ticks_r <= cfg_wdata[REG_W-1:0];
          REG_PHASE_GAP:    phase_gap_r    <= cfg_wdata[REG_W-1:0];
          REG_PROP_GAIN:    kp_r           <= cfg_wdata[GAIN_W-1:0];
          REG_INTEG_GAIN:   ki_r           <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // PI sequencer: next state
  always_comb begin
    case (pi_state_r)
      PI_ES:    pi_state_nxt = PI_M0;
      PI_M0:    pi_state_nxt = PI_M1;
      PI_M1:    pi_state_nxt = PI_M2;
      PI_M2:    pi_state_nxt = PI_M3;
      PI_M3:    pi_state_nxt = PI_M4;
      PI_M4:    pi_state_nxt = PI_I;
      PI_I:     pi_state_nxt = PI_T;
      PI_T:     pi_state_nxt = PI_READY;
      PI_READY: pi_state_nxt = PI_READY;
      default:  pi_state_nxt = PI_ES;
    endcase
    if (pi_restart) begin
      pi_state_nxt = PI_ES;
    end
  end

  // PI sequencer: multiplier operands
  always_comb begin
    case (pi_state_r)
      PI_M0: begin
        mul_a = fd_r[31:0];
        mul_b = kp_r;
      end
      PI_M1: begin
        mul_a = 32'(fd_r[FD_W-1:32]);
        mul_b = kp_r;
      end
      PI_M2: begin
        mul_a = mag_r[31:0];
        mul_b = ki_r;
      end
      PI_M3: begin
        mul_a = mag_r[63:32];
        mul_b = ki_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = {32'b0, mul_a} * {32'b0, mul_b};
  assign neg_fd   = -$signed({(ES_W-FD_W)'(0), fd_r});
  assign t_sum    = sat_add(t1_r, i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pi_state_r <= PI_ES;
    end else begin
      pi_state_r <= pi_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (pi_state_r)
      PI_ES: es1_r <= sat_add(es_r, neg_fd);
      PI_M0: begin
        mag_r <= es1_r[ES_W-1] ? ES_W'(-es1_r) : ES_W'(es1_r);
        neg_r <= es1_r[ES_W-1];
      end
      PI_M1: accp_r <= (FD_W+GAIN_W)'(prod_r);
      PI_M2: accp_r <= accp_r + {prod_r[FD_W-1:0], 32'b0};
      PI_M3: begin
        acci_r <= (ES_W+GAIN_W)'(prod_r);
        // floor of a negative product: -(ceil of magnitude)
        p_r <= ~ES_W'(accp_r[FD_W+GAIN_W-1:32]) + ES_W'(!(|accp_r[31:0]));
      end
      PI_M4: begin
        acci_r <= acci_r + {prod_r, 32'b0};
        t1_r   <= sat_add($signed({(ES_W-FD_W)'(0), fd_r}), p_r);
      end
      PI_I: begin
        if (neg_r) begin
          i_r <= ~acci_r[ES_W+GAIN_W-1:32] + ES_W'(!(|acci_r[31:0]));
        end else begin
          i_r <= acci_r[ES_W+GAIN_W-1:32];
        end
      end
      PI_T: begin
        if (fd_r == '0) begin
          pi_fd_r <= '0;
          pi_es_r <= es_r;
        end else begin
          pi_es_r <= es1_r;
          if (!t_sum[ES_W-1] && (|t_sum[ES_W-2:FRAC_W])) begin
            pi_fd_r <= (|t_sum[ES_W-2:FD_W]) ? {FD_W{1'b1}} : t_sum[FD_W-1:0];
          end else begin
            pi_fd_r <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // result register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r  <= skid_valid_r || acc;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gate_lines   = out_r.gate_lines;
  assign out_period_start = out_r.period_start;
  assign out_delay_whole  = out_r.delay_whole;

  ap_pi_ready: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tick && period_due |-> pi_state_r == PI_READY)
    else $error("period end taken before PI update was ready");

  ap_fd_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    fd_r == '0 && !cfg_we |=> fd_r == '0)
    else $error("firing delay left zero without a write");

  ap_es_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    es_r[ES_W-1] || es_r == '0)
    else $error("error sum went positive");

  ap_pi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pi_state_r == PI_READY |-> pi_fd_r <= fd_r)
    else $error("PI update would raise the firing delay");

  ap_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

endmodule

// ===== bench/tb_six_pulse_thyristor_firing_sequencer.sv =====
module tb_six_pulse_thyristor_firing_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import sptfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = CFG_IDX_W'(7);
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_TICKS  = 850;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  tick;
    logic                  known;
    res_t                  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_tick = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHANNELS-1:0]   out_gate_lines;
  logic                  out_period_start;
  logic [WHOLE_W-1:0]    out_delay_whole;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  six_pulse_thyristor_firing_sequencer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tick          (in_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_gate_lines   (out_gate_lines),
    .out_period_start (out_period_start),
    .out_delay_whole  (out_delay_whole),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // firing model state and its copy of the registers
  logic [REG_W-1:0]         lim_high, lim_period, lim_gap;
  logic [GAIN_W-1:0]        gain_p, gain_i;
  phase_t                   ch_ph  [CHANNELS];
  logic [CNT_W-1:0]         ch_cnt [CHANNELS];
  logic [CNT_W-1:0]         per_cnt;
  logic [FD_W-1:0]          fire_dly;
  logic signed [ES_W-1:0]   err_acc;
  logic [CHANNELS-1:0]      gates;

  res_t      firing_due[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        ticks_sent = 0;
  int        idle_run = 0;
  bit        calm = 1'b0;
  int        hold_asks = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [31:0] g);
    logic [63:0] hi_p, lo_p;
    hi_p = {32'd0, a[63:32]} * {32'd0, g};
    lo_p = {32'd0, a[31:0]} * {32'd0, g};
    return hi_p + (lo_p >> 32);
  endfunction

  // x * g / 2^32 rounded toward minus infinity
  function automatic logic signed [63:0] gain_floor(input logic signed [63:0] x,
                                                    input logic [31:0] g);
    logic [63:0] mag, q, lo_p;
    if (!x[63]) return $signed(mul_q32(x, g));
    mag = -x;
    q = mul_q32(mag, g);
    lo_p = {32'd0, mag[31:0]} * {32'd0, g};
    if (lo_p[31:0] != 32'd0) q = q + 64'd1;
    return -$signed(q);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic void pull_delay();
    logic signed [63:0] err, t;
    if (fire_dly == '0) return;
    err = -$signed({16'd0, fire_dly});
    err_acc = add_sat(err_acc, err);
    t = $signed({16'd0, fire_dly});
    t = add_sat(t, gain_floor(err, gain_p));
    t = add_sat(t, gain_floor(err_acc, gain_i));
    if (t >= 64'sh0000_0001_0000_0000)
      fire_dly = (t > 64'sh0000_FFFF_FFFF_FFFF) ? '1 : t[FD_W-1:0];
    else
      fire_dly = '0;
  endfunction

  function automatic res_t fire_step(input logic t);
    res_t r;
    logic began;
    logic hit;
    began = 1'b0;
    if (t) begin
      for (int i = 0; i < CHANNELS; i++) ch_cnt[i] = ch_cnt[i] + 1'b1;
      per_cnt = per_cnt + 1'b1;
      // period end is handled ahead of the channel checks
      if (per_cnt >= lim_period) begin
        pull_delay();
        ch_ph[0]  = PH_DELAY;
        ch_cnt[0] = '0;
        per_cnt   = '0;
        began     = 1'b1;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        hit = (i == 0) ? ({ch_cnt[0], 32'd0} >= fire_dly) : (ch_cnt[i] >= lim_gap);
        if (ch_ph[i] == PH_DELAY && hit) begin
          gates[i]  = 1'b1;
          ch_ph[i]  = PH_HIGH;
          ch_cnt[i] = '0;
          if (i + 1 < CHANNELS) begin
            ch_ph[i+1]  = PH_DELAY;
            ch_cnt[i+1] = '0;
          end
        end else if (ch_ph[i] == PH_HIGH && ch_cnt[i] >= lim_high) begin
          gates[i]  = 1'b0;
          ch_ph[i]  = PH_WAIT;
          ch_cnt[i] = '0;
        end
      end
    end
    r.gate_lines   = gates;
    r.period_start = began;
    r.delay_whole  = fire_dly[FD_W-1:FRAC_W];
    return r;
  endfunction

  function automatic plan_row_t row_wr(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    plan_row_t p;
    p      = '0;
    p.wr   = 1'b1;
    p.idx  = idx;
    p.data = data;
    return p;
  endfunction

  function automatic plan_row_t row_tk(input logic t, input logic known, input res_t want);
    plan_row_t p;
    p       = '0;
    p.tick  = t;
    p.known = known;
    p.want  = want;
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_setting(input logic [CFG_IDX_W-1:0] idx);
    logic [REG_W-1:0]  span, v16;
    logic [GAIN_W-1:0] g;
    int roll;
    roll = $urandom_range(0, 9);
    if (idx == REG_PROP_GAIN || idx == REG_INTEG_GAIN) begin
      case (roll)
        0:       g = '0;
        1:       g = '1;
        2, 3:    g = $urandom;
        default: g = $urandom >> $urandom_range(4, 31);
      endcase
      return g;
    end
    span = (idx == REG_START_DELAY) ? 16'd300 : (idx == REG_PERIOD_TICKS) ? 16'd90 : 16'd30;
    case (roll)
      0:       v16 = '0;
      1:       v16 = '1;
      default: v16 = REG_W'($urandom_range(0, span));
    endcase
    // upper bits are don't-care for the 16-bit registers
    return {16'($urandom), v16};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_START_DELAY:  fire_dly   = {data[REG_W-1:0], 32'd0};
      REG_HIGH_TICKS:   lim_high   = data[REG_W-1:0];
      REG_PERIOD_TICKS: lim_period = data[REG_W-1:0];
      REG_PHASE_GAP:    lim_gap    = data[REG_W-1:0];
      REG_PROP_GAIN:    gain_p     = data[GAIN_W-1:0];
      REG_INTEG_GAIN:   gain_i     = data[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic offer_tick(input logic t, input logic known, input res_t typed);
    res_t nxt;
    cfg_we <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      in_tick  <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nxt = fire_step(t);
    firing_due.push_back(known ? typed : nxt);
    if (t) ticks_sent++;
  endtask

  // drop valid and hold until every outstanding result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (firing_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (out_valid && !out_stall) begin
      if (firing_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = firing_due.pop_front();
        if (out_gate_lines !== want.gate_lines) begin
          $error("gate_lines: expected %0h, got %0h", want.gate_lines, out_gate_lines);
          mismatches++;
        end
        if (out_period_start !== want.period_start) begin
          $error("period_start: expected %0d, got %0d", want.period_start, out_period_start);
          mismatches++;
        end
        if (out_delay_whole !== want.delay_whole) begin
          $error("delay_whole: expected %0d, got %0d", want.delay_whole, out_delay_whole);
          mismatches++;
        end
      end
    end
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int phase_no;
    int burst;
    lim_high   = HIGH_TICKS_RST;
    lim_period = PERIOD_TICKS_RST;
    lim_gap    = PHASE_GAP_RST;
    gain_p     = PROP_GAIN_RST;
    gain_i     = INTEG_GAIN_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      ch_ph[i]  = PH_DELAY;
      ch_cnt[i] = '0;
    end
    per_cnt  = '0;
    fire_dly = {START_DELAY_RST, 32'd0};
    err_acc  = '0;
    gates    = '0;

    plan.push_back(row_tk(1'b0, 1'b1, res_t'{6'h00, 1'b0, 16'd208}));
    plan.push_back(row_tk(1'b1, 1'b1, res_t'{6'h00, 1'b0, 16'd208}));
    // all limits zero: every tick ends a period and fires the whole chain
    plan.push_back(row_wr(REG_START_DELAY, 32'd0));
    plan.push_back(row_wr(REG_HIGH_TICKS, 32'd0));
    plan.push_back(row_wr(REG_PERIOD_TICKS, 32'd0));
    plan.push_back(row_wr(REG_PHASE_GAP, 32'd0));
    plan.push_back(row_tk(1'b1, 1'b1, res_t'{6'h3F, 1'b1, 16'd0}));
    plan.push_back(row_tk(1'b0, 1'b1, res_t'{6'h3F, 1'b0, 16'd0}));
    plan.push_back(row_tk(1'b1, 1'b1, res_t'{6'h3F, 1'b1, 16'd0}));
    plan.push_back(row_wr(REG_START_DELAY, 32'hFFFF_FFFF));
    plan.push_back(row_wr(REG_PHASE_GAP, 32'h0000_FFFF));
    plan.push_back(row_wr(REG_PERIOD_TICKS, 32'h0000_FFFF));
    plan.push_back(row_wr(REG_HIGH_TICKS, 32'hFFFF_0000));
    plan.push_back(row_tk(1'b0, 1'b1, res_t'{6'h3F, 1'b0, 16'hFFFF}));
    plan.push_back(row_tk(1'b1, 1'b0, '0));
    plan.push_back(row_tk(1'b1, 1'b0, '0));
    // full gains collapse the delay to zero, where it stays
    plan.push_back(row_wr(REG_PROP_GAIN, 32'hFFFF_FFFF));
    plan.push_back(row_wr(REG_INTEG_GAIN, 32'hFFFF_FFFF));
    plan.push_back(row_wr(REG_PERIOD_TICKS, 32'd1));
    for (int n = 0; n < 3; n++) plan.push_back(row_tk(1'b1, 1'b0, '0));
    plan.push_back(row_wr(REG_NONE_LO, 32'hFFFF_FFFF));
    plan.push_back(row_wr(REG_NONE_HI, 32'd0));
    plan.push_back(row_wr(REG_START_DELAY, 32'd5));
    plan.push_back(row_wr(REG_HIGH_TICKS, 32'd2));
    plan.push_back(row_wr(REG_PERIOD_TICKS, 32'd9));
    plan.push_back(row_wr(REG_PHASE_GAP, 32'd1));
    plan.push_back(row_wr(REG_PROP_GAIN, 32'h4000_0000));
    plan.push_back(row_wr(REG_INTEG_GAIN, 32'h0100_0000));
    for (int n = 0; n < 10; n++) plan.push_back(row_tk(1'b1, 1'b0, '0));
    plan.push_back(row_tk(1'b0, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].wr) begin
        settle();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        offer_tick(plan[r].tick, plan[r].known, plan[r].want);
      end
    end

    ticks_sent = 0;
    phase_no = 0;
    while (ticks_sent < RAND_TICKS) begin
      phase_no++;
      settle();
      calm = (phase_no == 3);
      for (int k = REG_START_DELAY; k <= REG_INTEG_GAIN; k++) begin
        if (phase_no == 1 || $urandom_range(0, 9) < 6)
          write_reg(k[CFG_IDX_W-1:0], draw_setting(k[CFG_IDX_W-1:0]));
      end
      // back up the output side while requests keep coming
      if (phase_no == 5) hold_asks++;
      burst = $urandom_range(40, 140);
      repeat (burst) offer_tick($urandom_range(0, 99) < 85, 1'b0, '0);
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
